### design/twes_pkg.sv
// Shared types and constants for the two-wheel encoder target stop unit.
// No dependencies; used by twes_ticks, twes_core and the top level.
package twes_pkg;

	localparam int unsigned CountW  = 32;
	localparam int unsigned AmountW = 16;
	localparam int unsigned ScaleW  = 16;
	localparam int unsigned CodeW   = 4;
	localparam int unsigned FracW   = 12;

	// bridge direction codes accepted by a move
	localparam logic [CodeW-1:0] CODE_FORWARD    = 4'd10;
	localparam logic [CodeW-1:0] CODE_BACKWARD   = 4'd5;
	localparam logic [CodeW-1:0] CODE_TURN_LEFT  = 4'd9;
	localparam logic [CodeW-1:0] CODE_TURN_RIGHT = 4'd6;

	// one half of the bridge code (one wheel)
	localparam logic [1:0] HALF_BACK = 2'b01;
	localparam logic [1:0] HALF_FWD  = 2'b10;

	localparam logic STATUS_GOOD    = 1'b0;
	localparam logic STATUS_BAD_DIR = 1'b1;

	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] REG_TICKS_PER_CM     = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_TICKS_PER_DEGREE = 1'd1;
	localparam logic [ScaleW-1:0]  SCALE_RESET          = 16'd256;

	typedef enum logic [1:0] {
		MODE_MOVE    = 2'd0,
		MODE_PULSE_L = 2'd1,
		MODE_PULSE_R = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// item after the tick conversion, held in the input stage
	typedef struct packed {
		mode_t             mode;
		logic [CodeW-1:0]  dir;
		logic [CountW-1:0] ticks;
	} item_t;

	typedef struct packed {
		logic              status;
		logic              left_on;
		logic              right_on;
		logic [CodeW-1:0]  bridge;
		logic [CountW-1:0] left_pos;
		logic [CountW-1:0] right_pos;
	} result_t;

	function automatic logic code_valid(input logic [CodeW-1:0] c);
		return (c == CODE_FORWARD) || (c == CODE_BACKWARD) ||
			(c == CODE_TURN_LEFT) || (c == CODE_TURN_RIGHT);
	endfunction

endpackage

### design/two_wheel_encoder_target_stop_unit.sv
// Two-wheel encoder position counter with target stop, top level.
// Depends on twes_pkg, twes_ticks and twes_core.
//
// s_*: s_tuser carries the item kind (move, left pulse, right pulse, mode 3
//   ignored); s_tdata carries the bridge code and the signed Q12.4 amount.
//   Every item yields exactly one result on m_*.
// m_*: m_tuser carries the status (1 = invalid bridge code on a move, nothing
//   changed); m_tdata carries the drive enables, the bridge code and both
//   wheel counts after the item.
// cfg_*: index 0 writes ticks_per_cm, index 1 writes ticks_per_degree
//   (unsigned Q8.8). Always ready; write only while no item is in flight.
// Pipeline: the amount times scale product is taken into the input stage at
//   the accepting edge; the count/target update and compares load the output
//   register as the input stage advances, raising m_tvalid. One item per
//   cycle is sustained with m_tready high; the multiplier sets the input path.
// Stall: with m_tready low the output register holds its result, the input
//   stage takes one more item, and s_tready drops once both are full.
// Reset: arst_n clears counts, targets, bridge code, enables and both stage
//   valids, and sets both scales to 1.0.
module two_wheel_encoder_target_stop_unit
	import twes_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// slave stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,  // [3:0] direction, [19:4] amount, rest zero
	input  logic [1:0]         s_tuser,  // [1:0] mode
	// master stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [71:0]        m_tdata,  // [0] left_drive_on, [1] right_drive_on,
	                                     // [5:2] bridge_out, [37:6] left_position,
	                                     // [69:38] right_position, rest zero
	output logic               m_tuser,  // [0] status
	// configuration write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ScaleW-1:0]  cfg_data
);

	logic [ScaleW-1:0] ticks_per_cm_q, ticks_per_degree_q;
	logic [CountW-1:0] ticks;
	item_t             item_s1;
	logic              valid_s1;
	logic              advance;
	result_t           res;
	result_t           res_s2;
	logic              valid_s2;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_cm_q     <= SCALE_RESET;
			ticks_per_degree_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TICKS_PER_CM:     ticks_per_cm_q     <= cfg_data;
				REG_TICKS_PER_DEGREE: ticks_per_degree_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	twes_ticks u_ticks (
		.direction        (s_tdata[3:0]),
		.amount           (s_tdata[19:4]),
		.ticks_per_cm     (ticks_per_cm_q),
		.ticks_per_degree (ticks_per_degree_q),
		.ticks            (ticks)
	);

	// input stage advances into the output register whenever it is free
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode  <= mode_t'(s_tuser);
			item_s1.dir   <= s_tdata[3:0];
			item_s1.ticks <= ticks;
		end
	end

	twes_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.status;
	assign m_tdata  = {2'b00, res_s2.right_pos, res_s2.left_pos, res_s2.bridge,
		res_s2.right_on, res_s2.left_on};

`ifndef SYNTH
	// a blocked input stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost or changed a stalled item");

	// the slave side stalls only with both stages full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("s_tready low with room in the pipeline");

	// the bridge code driven out is idle or one of the move codes
	a_bridge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s2.bridge == '0) || (res_s2.bridge == CODE_FORWARD) ||
			(res_s2.bridge == CODE_BACKWARD) || (res_s2.bridge == CODE_TURN_LEFT) ||
			(res_s2.bridge == CODE_TURN_RIGHT))
		else $error("bridge code outside the move codes");

	// only a move with a bad bridge code reports an error
	a_bad_move: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.status |-> (item_s1.mode == MODE_MOVE) && !code_valid(item_s1.dir))
		else $error("error status on an item that is not a rejected move");
`endif

endmodule

### design/twes_ticks.sv
// Amount to encoder tick conversion: Q12.4 amount times Q8.8 scale,
// rounded half away from zero. Depends on twes_pkg.
module twes_ticks
	import twes_pkg::*;
(
	input  logic [CodeW-1:0]         direction,
	input  logic signed [AmountW-1:0] amount,
	input  logic [ScaleW-1:0]        ticks_per_cm,
	input  logic [ScaleW-1:0]        ticks_per_degree,
	output logic [CountW-1:0]        ticks
);

	localparam int unsigned MagW  = AmountW + 1;
	localparam int unsigned ProdW = MagW + ScaleW;
	localparam int unsigned TickW = ProdW - FracW;

	logic              neg;
	logic [MagW-1:0]   mag;
	logic [ScaleW-1:0] scale;
	logic [ProdW-1:0]  prod;
	logic [ProdW-1:0]  rounded;
	logic [TickW-1:0]  tick_mag;
	logic [CountW-1:0] tick_ext;

	assign neg   = amount[AmountW-1];
	assign mag   = neg ? (MagW'(0) - {amount[AmountW-1], amount})
		: {1'b0, amount};
	assign scale = ((direction == CODE_TURN_LEFT) || (direction == CODE_TURN_RIGHT))
		? ticks_per_degree : ticks_per_cm;
	assign prod     = ProdW'(mag) * ProdW'(scale);
	assign rounded  = prod + ProdW'(1 << (FracW - 1));
	assign tick_mag = rounded[ProdW-1:FracW];
	assign tick_ext = CountW'(tick_mag);
	assign ticks    = neg ? (CountW'(0) - tick_ext) : tick_ext;

endmodule

### design/twes_core.sv
// Wheel counts, targets, drive enables and bridge code, with the
// next-state logic for one item. Depends on twes_pkg.
module twes_core
	import twes_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t res
);

	logic [CountW-1:0] left_count_q, right_count_q;
	logic [CountW-1:0] left_target_q, right_target_q;
	logic [CodeW-1:0]  bridge_q;
	logic              left_en_q, right_en_q;

	logic [CountW-1:0] left_count_d, right_count_d;
	logic [CountW-1:0] left_target_d, right_target_d;
	logic [CodeW-1:0]  bridge_d;
	logic              left_en_d, right_en_d;
	logic              status_d;

	always_comb begin
		left_count_d   = left_count_q;
		right_count_d  = right_count_q;
		left_target_d  = left_target_q;
		right_target_d = right_target_q;
		bridge_d       = bridge_q;
		left_en_d      = left_en_q;
		right_en_d     = right_en_q;
		status_d       = STATUS_GOOD;
		unique case (item.mode)
			MODE_MOVE: begin
				if (!code_valid(item.dir)) begin
					status_d = STATUS_BAD_DIR;
				end else begin
					left_en_d  = 1'b1;
					right_en_d = 1'b1;
					bridge_d   = item.dir;
					unique case (item.dir[1:0])
						HALF_BACK: left_target_d = left_count_q - item.ticks;
						HALF_FWD:  left_target_d = left_count_q + item.ticks;
						default:   left_target_d = left_count_q;
					endcase
					unique case (item.dir[3:2])
						HALF_BACK: right_target_d = right_count_q - item.ticks;
						HALF_FWD:  right_target_d = right_count_q + item.ticks;
						default:   right_target_d = right_count_q;
					endcase
				end
			end
			MODE_PULSE_L: begin
				unique case (bridge_q[1:0])
					HALF_BACK: left_count_d = left_count_q - CountW'(1);
					HALF_FWD:  left_count_d = left_count_q + CountW'(1);
					default:   left_count_d = left_count_q;
				endcase
				// stop the drive once the target is reached
				if (left_count_d == left_target_q) begin
					left_en_d = 1'b0;
				end
			end
			MODE_PULSE_R: begin
				unique case (bridge_q[3:2])
					HALF_BACK: right_count_d = right_count_q - CountW'(1);
					HALF_FWD:  right_count_d = right_count_q + CountW'(1);
					default:   right_count_d = right_count_q;
				endcase
				if (right_count_d == right_target_q) begin
					right_en_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q   <= '0;
			right_count_q  <= '0;
			left_target_q  <= '0;
			right_target_q <= '0;
			bridge_q       <= '0;
			left_en_q      <= 1'b0;
			right_en_q     <= 1'b0;
		end else if (step) begin
			left_count_q   <= left_count_d;
			right_count_q  <= right_count_d;
			left_target_q  <= left_target_d;
			right_target_q <= right_target_d;
			bridge_q       <= bridge_d;
			left_en_q      <= left_en_d;
			right_en_q     <= right_en_d;
		end
	end

	assign res.status    = status_d;
	assign res.left_on   = left_en_d;
	assign res.right_on  = right_en_d;
	assign res.bridge    = bridge_d;
	assign res.left_pos  = left_count_d;
	assign res.right_pos = right_count_d;

endmodule

### test/tb_two_wheel_encoder_target_stop_unit.sv
// Testbench for the two-wheel encoder target stop unit: drives moves and encoder pulses,
// predicts every result in place and compares it field by field with the output stream.
// Depends on twes_pkg and the design under test two_wheel_encoder_target_stop_unit.
module tb_two_wheel_encoder_target_stop_unit
	import twes_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;

	typedef struct {
		mode_t            mode;
		logic [CodeW-1:0] dir;
		logic [15:0]      amount;
	} cmd_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [23:0]        s_tdata = '0;
	logic [1:0]         s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [71:0]        m_tdata;
	logic               m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [ScaleW-1:0]  cfg_data = '0;

	two_wheel_encoder_target_stop_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// wheel state as the block should hold it
	logic [31:0]       pos_l = '0, pos_r = '0, goal_l = '0, goal_r = '0;
	logic [CodeW-1:0]  bridge_now = '0;
	logic              run_l = 1'b0, run_r = 1'b0;
	logic [ScaleW-1:0] scale_cm = SCALE_RESET, scale_deg = SCALE_RESET;

	cmd_t    pending_cmds[$];
	cmd_t    on_bus;
	result_t expected_results[$];

	// scales as last written, used only to shape the stimulus
	logic [ScaleW-1:0] set_cm = SCALE_RESET, set_deg = SCALE_RESET;

	int  items_queued = 0;
	int  fail_count = 0;
	int  quiet_cycles = 0;
	int  src_gap = 0;
	int  sink_gap = 0;
	bit  no_gaps = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic is_turn(input logic [CodeW-1:0] code);
		return code == CODE_TURN_LEFT || code == CODE_TURN_RIGHT;
	endfunction

	// signed tick count, rounded half away from zero
	function automatic logic [31:0] move_ticks(input logic [CodeW-1:0] code,
			input logic [15:0] amt);
		logic [16:0] mag;
		logic [15:0] scale;
		logic [47:0] prod;
		logic [31:0] ticks;
		mag = amt[15] ? (17'h10000 - {1'b0, amt}) : {1'b0, amt};
		scale = is_turn(code) ? scale_deg : scale_cm;
		prod = 48'(mag) * 48'(scale);
		ticks = 32'((prod + 48'd2048) >> FracW);
		return amt[15] ? (32'd0 - ticks) : ticks;
	endfunction

	function automatic result_t apply_item(input cmd_t cmd);
		result_t res;
		logic [31:0] t;
		res.status = STATUS_GOOD;
		case (cmd.mode)
			MODE_MOVE: begin
				if (cmd.dir != CODE_FORWARD && cmd.dir != CODE_BACKWARD &&
						!is_turn(cmd.dir)) begin
					res.status = STATUS_BAD_DIR;
				end else begin
					t = move_ticks(cmd.dir, cmd.amount);
					run_l = 1'b1;
					run_r = 1'b1;
					goal_l = pos_l;
					goal_r = pos_r;
					if (cmd.dir[1:0] == HALF_BACK) goal_l = goal_l - t;
					else if (cmd.dir[1:0] == HALF_FWD) goal_l = goal_l + t;
					if (cmd.dir[3:2] == HALF_BACK) goal_r = goal_r - t;
					else if (cmd.dir[3:2] == HALF_FWD) goal_r = goal_r + t;
					bridge_now = cmd.dir;
				end
			end
			MODE_PULSE_L: begin
				if (bridge_now[1:0] == HALF_BACK) pos_l = pos_l - 1;
				else if (bridge_now[1:0] == HALF_FWD) pos_l = pos_l + 1;
				if (pos_l == goal_l) run_l = 1'b0;
			end
			MODE_PULSE_R: begin
				if (bridge_now[3:2] == HALF_BACK) pos_r = pos_r - 1;
				else if (bridge_now[3:2] == HALF_FWD) pos_r = pos_r + 1;
				if (pos_r == goal_r) run_r = 1'b0;
			end
			default: ;
		endcase
		res.left_on = run_l;
		res.right_on = run_r;
		res.bridge = bridge_now;
		res.left_pos = pos_l;
		res.right_pos = pos_r;
		return res;
	endfunction

	// driver: feed pending items, predict each one as it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TICKS_PER_CM) scale_cm = cfg_data;
				else if (cfg_index == REG_TICKS_PER_DEGREE) scale_deg = cfg_data;
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_item(on_bus));
			if (s_tvalid && !s_tready) begin
				// hold the item on the bus
			end else if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0 && !no_gaps && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 2);
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				on_bus = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, on_bus.amount, on_bus.dir};
				s_tuser <= on_bus.mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: compare each result with the oldest expectation, stall at random
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.left_on = m_tdata[0];
				got.right_on = m_tdata[1];
				got.bridge = m_tdata[5:2];
				got.left_pos = m_tdata[37:6];
				got.right_pos = m_tdata[69:38];
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0b bridge %0d", got.status,
							got.bridge);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.left_on !== want.left_on ||
							got.right_on !== want.right_on || got.bridge !== want.bridge ||
							got.left_pos !== want.left_pos ||
							got.right_pos !== want.right_pos) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch exp: st %0b on %0b%0b br %0d pos %0d %0d",
								want.status, want.left_on, want.right_on, want.bridge,
								$signed(want.left_pos), $signed(want.right_pos));
							$display("         got: st %0b on %0b%0b br %0d pos %0d %0d",
								got.status, got.left_on, got.right_on, got.bridge,
								$signed(got.left_pos), $signed(got.right_pos));
						end
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic push_cmd(input mode_t mode, input logic [CodeW-1:0] dir,
			input logic [15:0] amt);
		cmd_t cmd;
		cmd.mode = mode;
		cmd.dir = dir;
		cmd.amount = amt;
		pending_cmds.push_back(cmd);
		if (mode != MODE_NONE) items_queued++;
	endtask

	// one move followed by about enough pulses to reach both targets
	task automatic queue_trip();
		logic [CodeW-1:0] code;
		logic [15:0] scale;
		logic [15:0] amt;
		int lim, mag, est, left_n, right_n;
		case ($urandom_range(0, 3))
			0: code = CODE_FORWARD;
			1: code = CODE_BACKWARD;
			2: code = CODE_TURN_LEFT;
			default: code = CODE_TURN_RIGHT;
		endcase
		scale = is_turn(code) ? set_deg : set_cm;
		lim = (scale == 0) ? 32767 : (24 * 4096) / int'(scale);
		if (lim > 32767) lim = 32767;
		mag = $urandom_range(0, lim);
		est = (mag * int'(scale) + 2048) >> FracW;
		amt = 16'(mag);
		if ($urandom_range(0, 3) == 0) amt = 16'(-mag);
		push_cmd(MODE_MOVE, code, amt);
		left_n = est + $urandom_range(0, 2);
		right_n = est + $urandom_range(0, 2);
		// break off some sequences early
		if ($urandom_range(0, 7) == 0) left_n = left_n / 2;
		if ($urandom_range(0, 7) == 0) right_n = right_n / 2;
		while (left_n + right_n > 0) begin
			if (right_n == 0 || (left_n > 0 && $urandom_range(0, 1) == 1)) begin
				push_cmd(MODE_PULSE_L, 4'($urandom), 16'($urandom));
				left_n--;
			end else begin
				push_cmd(MODE_PULSE_R, 4'($urandom), 16'($urandom));
				right_n--;
			end
		end
	endtask

	task automatic run_mix(input int n_items);
		int start;
		start = items_queued;
		while (items_queued - start < n_items) begin
			if ($urandom_range(0, 4) == 0)
				push_cmd(mode_t'(2'($urandom)), 4'($urandom), 16'($urandom));
			else
				queue_trip();
		end
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both scales back to back, keeping valid high between them
	task automatic write_scales(input logic [ScaleW-1:0] cm, input logic [ScaleW-1:0] deg);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TICKS_PER_CM;
		cfg_data <= cm;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_TICKS_PER_DEGREE;
		cfg_data <= deg;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_cm = cm;
		set_deg = deg;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		push_cmd(MODE_NONE, 4'hF, 16'hFFFF);
		push_cmd(MODE_PULSE_L, 4'h0, 16'h0000);
		push_cmd(MODE_MOVE, 4'h0, 16'h0010);
		push_cmd(MODE_MOVE, 4'hF, 16'h7FFF);
		push_cmd(MODE_MOVE, 4'h3, 16'h8000);
		push_cmd(MODE_MOVE, CODE_FORWARD, 16'h0030);
		repeat (3) push_cmd(MODE_PULSE_L, 4'h0, 16'h0000);
		repeat (3) push_cmd(MODE_PULSE_R, 4'h0, 16'h0000);
		// drive already off: count still moves
		push_cmd(MODE_PULSE_L, 4'h0, 16'h0000);
		push_cmd(MODE_MOVE, CODE_BACKWARD, 16'h7FFF);
		push_cmd(MODE_PULSE_R, 4'h0, 16'h0000);
		push_cmd(MODE_MOVE, CODE_BACKWARD, 16'h8000);
		push_cmd(MODE_PULSE_L, 4'h0, 16'h0000);
		// 1.5 and -1.5 degrees round away from zero
		push_cmd(MODE_MOVE, CODE_TURN_LEFT, 16'h0018);
		push_cmd(MODE_PULSE_L, 4'h0, 16'h0000);
		push_cmd(MODE_PULSE_R, 4'h0, 16'h0000);
		push_cmd(MODE_MOVE, CODE_TURN_RIGHT, 16'hFFE8);
		push_cmd(MODE_MOVE, CODE_FORWARD, 16'h0000);
		push_cmd(MODE_PULSE_R, 4'h0, 16'h0000);
		push_cmd(MODE_MOVE, CODE_FORWARD, 16'hFFF8);
		wait_idle();

		run_mix(170);
		wait_idle();
		write_scales(16'd0, 16'hFFFF);
		run_mix(170);
		wait_idle();
		write_scales(16'hFFFF, 16'd0);
		run_mix(170);
		wait_idle();
		write_scales(16'($urandom), 16'($urandom));
		run_mix(170);
		wait_idle();
		write_scales(16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)));
		run_mix(170);
		wait_idle();
		// last part runs without idling on either side
		no_gaps = 1'b1;
		write_scales(16'($urandom), 16'($urandom));
		run_mix(170);
		wait_idle();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### two_wheel_encoder_target_stop_unit.f
design/twes_pkg.sv
design/twes_ticks.sv
design/twes_core.sv
design/two_wheel_encoder_target_stop_unit.sv
test/tb_two_wheel_encoder_target_stop_unit.sv
